// ----- rtl/core/ping_window_average_jitter_macros.svh -----
// Assertion macros for the RTL of the latency statistics block; only pwaj_back.sv includes them.
`ifndef PING_WINDOW_AVERAGE_JITTER_MACROS_SVH
`define PING_WINDOW_AVERAGE_JITTER_MACROS_SVH

`ifndef SYNTHESIS
`define PWAJ_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PWAJ_ASSERT(label, prop, msg) `PWAJ_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)
`else
`define PWAJ_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define PWAJ_ASSERT(label, prop, msg)
`endif

`endif

// ----- rtl/core/pwaj_pkg.sv -----
`timescale 1ns / 1ps

package pwaj_pkg;

  localparam int IN_BITS  = 16;
  localparam int OUT_BITS = 16;
  localparam int CFG_BITS = 7;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd16;

  typedef struct packed {
    logic recompute;
    logic full;
  } pwaj_flags_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_AVG_START,
    ST_AVG_WAIT,
    ST_JIT_START,
    ST_JIT_WAIT,
    ST_WRITE
  } pwaj_state_e;

endpackage

// ----- rtl/core/pwaj_fifo.sv -----
`timescale 1ns / 1ps

module pwaj_fifo import pwaj_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] ptr);
    next_ptr = (ptr == PW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/pwaj_front.sv -----
`timescale 1ns / 1ps

module pwaj_front import pwaj_pkg::*; #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int CW          = $clog2(WINDOW_MAX + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_BITS-1:0]    cfg_data_i,
  input  logic                   push_i,
  output logic                   full_o,
  input  logic [IN_BITS-1:0]     latency_ms_i,
  output logic                   q_push_o,
  input  logic                   q_full_i,
  output logic [SAMPLE_BITS-1:0] q_sample_o,
  output logic [CW-1:0]          q_count_o,
  output pwaj_flags_t            q_flags_o
);

  localparam int LW = (CW > CFG_BITS) ? CW : CFG_BITS;

  logic [CFG_BITS-1:0] len_q;
  logic [CW-1:0]       fill_q;
  logic [LW-1:0]       len_ext, eff_len, fill_ext, base, fill_d;
  logic                accept;

  assign cfg_ready_o = 1'b1;
  assign full_o      = q_full_i;
  assign accept      = push_i & ~q_full_i;
  assign q_push_o    = accept;

  generate
    if (SAMPLE_BITS >= IN_BITS) begin : g_wide
      assign q_sample_o = SAMPLE_BITS'(latency_ms_i);
    end else begin : g_sat
      assign q_sample_o = (latency_ms_i > IN_BITS'({SAMPLE_BITS{1'b1}})) ? '1 :
                          latency_ms_i[SAMPLE_BITS-1:0];
    end
  endgenerate

  always_comb begin
    len_ext = LW'(len_q);
    if (len_ext == '0) begin
      eff_len = LW'(1);
    end else if (len_ext > LW'(WINDOW_MAX)) begin
      eff_len = LW'(WINDOW_MAX);
    end else begin
      eff_len = len_ext;
    end
    fill_ext = LW'(fill_q);
    q_flags_o.recompute = (fill_ext >= eff_len);
    base   = q_flags_o.recompute ? eff_len - 1'b1 : fill_ext;
    fill_d = base + 1'b1;
    q_flags_o.full = (fill_d >= eff_len);
  end

  assign q_count_o = fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= CFG_RESET;
      fill_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        len_q <= cfg_data_i;
      end
      if (accept) begin
        fill_q <= CW'(fill_d);
      end
    end
  end

endmodule

// ----- rtl/core/pwaj_div.sv -----
`timescale 1ns / 1ps

module pwaj_div import pwaj_pkg::*; #(
  parameter int DW = 23,
  parameter int VW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int NW = $clog2(DW + 1);

  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q, dvs_q;
  logic [NW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [VW:0]   shifted;
  logic [VW+1:0] diff;

  assign shifted    = {rem_q, quo_q[DW-1]};
  assign diff       = {1'b0, shifted} - (VW + 2)'(dvs_q);
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (diff[VW+1]) begin
        rem_q <= shifted[VW-1:0];
        quo_q <= {quo_q[DW-2:0], 1'b0};
      end else begin
        rem_q <= diff[VW-1:0];
        quo_q <= {quo_q[DW-2:0], 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= NW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == NW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/pwaj_back.sv -----
`timescale 1ns / 1ps
`include "ping_window_average_jitter_macros.svh"

module pwaj_back import pwaj_pkg::*; #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int CW          = $clog2(WINDOW_MAX + 1),
  parameter int SW          = SAMPLE_BITS + CW
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_empty_i,
  output logic                   q_pop_o,
  input  logic [SAMPLE_BITS-1:0] q_sample_i,
  input  logic [CW-1:0]          q_count_i,
  input  pwaj_flags_t            q_flags_i,
  output logic                   div_start_o,
  output logic [SW-1:0]          div_dividend_o,
  output logic [CW-1:0]          div_divisor_o,
  input  logic                   div_done_i,
  input  logic [SW-1:0]          div_quotient_i,
  input  logic                   res_full_i,
  output logic                   res_push_o,
  output logic [OUT_BITS-1:0]    res_average_o,
  output logic [OUT_BITS-1:0]    res_jitter_o,
  output logic                   res_window_full_o
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  pwaj_state_e state_q, state_d;

  logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] sample_q, rd_data_q, prev_q, abs_diff;
  logic [CW-1:0]          count_q, iss_q, acc_q;
  pwaj_flags_t            flags_q;
  logic [AW-1:0]          newest_q, rd_pos_q, wr_addr;
  logic                   rd_vld_q, issue, mem_we;
  logic [SW-1:0]          sum_q, diff_q;
  logic [OUT_BITS-1:0]    avg_q, jit_q;
  logic                   div_awaited;

  function automatic logic [AW-1:0] older(input logic [AW-1:0] pos);
    older = (pos == '0) ? AW'(WINDOW_MAX - 1) : pos - 1'b1;
  endfunction

  function automatic logic [AW-1:0] newer(input logic [AW-1:0] pos);
    newer = (pos == AW'(WINDOW_MAX - 1)) ? '0 : pos + 1'b1;
  endfunction

  assign wr_addr  = newer(newest_q);
  assign abs_diff = (rd_data_q > prev_q) ? rd_data_q - prev_q : prev_q - rd_data_q;

  assign div_dividend_o    = (state_q == ST_AVG_START) ? sum_q : diff_q;
  assign div_divisor_o     = count_q;
  assign res_average_o     = avg_q;
  assign res_jitter_o      = jit_q;
  assign res_window_full_o = flags_q.full;
  assign div_awaited       = (state_q == ST_AVG_WAIT) || (state_q == ST_JIT_WAIT);

  always_comb begin
    state_d     = state_q;
    q_pop_o     = 1'b0;
    issue       = 1'b0;
    div_start_o = 1'b0;
    mem_we      = 1'b0;
    res_push_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = q_flags_i.recompute ? ST_WALK : ST_WRITE;
        end
      end
      ST_WALK: begin
        issue = (iss_q != count_q);
        if (rd_vld_q && (acc_q == count_q - 1'b1)) begin
          state_d = ST_AVG_START;
        end
      end
      ST_AVG_START: begin
        div_start_o = 1'b1;
        state_d     = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (div_done_i) begin
          state_d = ST_JIT_START;
        end
      end
      ST_JIT_START: begin
        div_start_o = 1'b1;
        state_d     = ST_JIT_WAIT;
      end
      ST_JIT_WAIT: begin
        if (div_done_i) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!res_full_i) begin
          mem_we     = 1'b1;
          res_push_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= sample_q;
    end
    rd_data_q <= mem[rd_pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      sample_q <= q_sample_i;
      count_q  <= q_count_i;
      rd_pos_q <= newest_q;
      iss_q    <= '0;
      acc_q    <= '0;
      sum_q    <= '0;
      diff_q   <= '0;
      prev_q   <= '0;
    end else begin
      if (issue) begin
        rd_pos_q <= older(rd_pos_q);
        iss_q    <= iss_q + 1'b1;
      end
      if (rd_vld_q) begin
        sum_q  <= sum_q + SW'(rd_data_q);
        if (prev_q != '0) begin
          diff_q <= diff_q + SW'(abs_diff);
        end
        prev_q <= rd_data_q;
        acc_q  <= acc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      flags_q  <= '0;
      newest_q <= '0;
      rd_vld_q <= 1'b0;
      avg_q    <= '0;
      jit_q    <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (q_pop_o) begin
        flags_q <= q_flags_i;
      end
      if (mem_we) begin
        newest_q <= wr_addr;
      end
      if (div_done_i && state_q == ST_AVG_WAIT) begin
        avg_q <= OUT_BITS'(div_quotient_i);
      end
      if (div_done_i && state_q == ST_JIT_WAIT) begin
        jit_q <= OUT_BITS'(div_quotient_i);
      end
    end
  end

  `PWAJ_ASSERT(a_acc_behind_issue, state_q == ST_WALK |-> acc_q <= iss_q, "read data overran")
  `PWAJ_ASSERT(a_div_done_waiting, div_done_i |-> div_awaited, "divider finished unawaited")
  `PWAJ_ASSERT(a_pop_work, q_pop_o |=> (state_q == ST_WALK || state_q == ST_WRITE), "no work")

endmodule

// ----- rtl/core/ping_window_average_jitter.sv -----
`timescale 1ns / 1ps
// Path: a sample that triggers no recomputation passes through the item queue, the back end's
// ST_IDLE and ST_WRITE states and the result queue. A recomputing sample also walks the
// sample memory, one read per cycle, and then uses the shared bit-serial divider for the
// average and then the jitter. The back end pops a new item only in ST_IDLE, after it is through
// with the last one; two queue slots on each side absorb stalls.
// Reset: asynchronous, active low; clears counts, held statistics and sets the length to 16.

module ping_window_average_jitter import pwaj_pkg::*; #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_BITS-1:0] cfg_data_i,
  input  logic                push,
  output logic                full,
  input  logic [IN_BITS-1:0]  latency_ms_i,
  output logic                empty,
  input  logic                pop,
  output logic [OUT_BITS-1:0] average_ms_o,
  output logic [OUT_BITS-1:0] jitter_ms_o,
  output logic                window_full_o
);

  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int SW = SAMPLE_BITS + CW;
  localparam int FW = $bits(pwaj_flags_t);
  localparam int IW = SAMPLE_BITS + CW + FW;
  localparam int RW = 2 * OUT_BITS + 1;

  logic                   f_push, q_full, q_empty, q_pop;
  logic [SAMPLE_BITS-1:0] f_sample, q_sample;
  logic [CW-1:0]          f_count, q_count;
  pwaj_flags_t            f_flags, q_flags;
  logic [IW-1:0]          q_rd_data;
  logic                   div_start, div_done;
  logic [SW-1:0]          div_dividend, div_quotient;
  logic [CW-1:0]          div_divisor;
  logic                   r_full, r_push, r_window_full;
  logic [OUT_BITS-1:0]    r_average, r_jitter;
  logic [RW-1:0]          r_rd_data;

  pwaj_front #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS),
    .CW         (CW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .full_o      (full),
    .latency_ms_i(latency_ms_i),
    .q_push_o    (f_push),
    .q_full_i    (q_full),
    .q_sample_o  (f_sample),
    .q_count_o   (f_count),
    .q_flags_o   (f_flags)
  );

  pwaj_fifo #(
    .WIDTH(IW),
    .DEPTH(2)
  ) u_item_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_push),
    .full_o (q_full),
    .data_i ({f_sample, f_count, f_flags}),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (q_rd_data)
  );

  assign q_sample = q_rd_data[IW-1 -: SAMPLE_BITS];
  assign q_count  = q_rd_data[FW +: CW];
  assign q_flags  = pwaj_flags_t'(q_rd_data[FW-1:0]);

  pwaj_back #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS),
    .CW         (CW),
    .SW         (SW)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_pop_o          (q_pop),
    .q_sample_i       (q_sample),
    .q_count_i        (q_count),
    .q_flags_i        (q_flags),
    .div_start_o      (div_start),
    .div_dividend_o   (div_dividend),
    .div_divisor_o    (div_divisor),
    .div_done_i       (div_done),
    .div_quotient_i   (div_quotient),
    .res_full_i       (r_full),
    .res_push_o       (r_push),
    .res_average_o    (r_average),
    .res_jitter_o     (r_jitter),
    .res_window_full_o(r_window_full)
  );

  pwaj_div #(
    .DW(SW),
    .VW(CW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quotient)
  );

  pwaj_fifo #(
    .WIDTH(RW),
    .DEPTH(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (r_push),
    .full_o (r_full),
    .data_i ({r_average, r_jitter, r_window_full}),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (r_rd_data)
  );

  assign average_ms_o  = r_rd_data[RW-1 -: OUT_BITS];
  assign jitter_ms_o   = r_rd_data[OUT_BITS:1];
  assign window_full_o = r_rd_data[0];

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import pwaj_pkg::*;

  localparam int WIN_MAX = 64;
  localparam int N_PHASES = 16;
  localparam int PHASE_BEATS = 110;
  localparam int EXP_DEPTH = 16;
  localparam int MAX_ROWS = 32;

  typedef struct packed {
    logic [OUT_BITS-1:0] average;
    logic [OUT_BITS-1:0] jitter;
    logic                full;
  } stats_t;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [IN_BITS-1:0] value;
    logic               typed;
    stats_t             stats;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_BITS-1:0] cfg_data_i = '0;
  logic                push = 1'b0;
  logic                full;
  logic [IN_BITS-1:0]  latency_ms_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [OUT_BITS-1:0] average_ms_o;
  logic [OUT_BITS-1:0] jitter_ms_o;
  logic                window_full_o;

  logic [IN_BITS-1:0]  sample_mem [WIN_MAX];
  int unsigned         fill_cnt = 0;
  int unsigned         newest_slot = 0;
  logic [OUT_BITS-1:0] avg_hold = '0;
  logic [OUT_BITS-1:0] jit_hold = '0;
  logic [CFG_BITS-1:0] win_len = CFG_RESET;

  stats_t              exp_mem [EXP_DEPTH];
  int                  exp_wr = 0;
  int                  exp_rd = 0;
  row_t                dir_rows [MAX_ROWS];
  int                  n_rows = 0;
  int                  failures = 0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;

  ping_window_average_jitter uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .latency_ms_i (latency_ms_i),
    .empty        (empty),
    .pop          (pop),
    .average_ms_o (average_ms_o),
    .jitter_ms_o  (jitter_ms_o),
    .window_full_o(window_full_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic stats_t advance_window(input logic [IN_BITS-1:0] v);
    int unsigned eff;
    int unsigned sum;
    int unsigned diffs;
    int unsigned prev;
    int unsigned cur;
    int unsigned slot;
    int unsigned i;
    stats_t      r;
    eff = (win_len == 0) ? 1 : ((win_len > WIN_MAX) ? WIN_MAX : win_len);
    if (fill_cnt >= eff) begin
      sum = 0;
      diffs = 0;
      prev = 0;
      slot = newest_slot;
      for (i = 0; i < fill_cnt; i++) begin
        cur = sample_mem[slot];
        sum += cur;
        if (prev != 0) begin
          diffs += (cur > prev) ? (cur - prev) : (prev - cur);
        end
        prev = cur;
        slot = (slot == 0) ? WIN_MAX - 1 : slot - 1;
      end
      avg_hold = OUT_BITS'(sum / fill_cnt);
      jit_hold = OUT_BITS'(diffs / fill_cnt);
      fill_cnt = eff - 1;
    end
    newest_slot = (newest_slot + 1) % WIN_MAX;
    sample_mem[newest_slot] = v;
    fill_cnt++;
    r.average = avg_hold;
    r.jitter = jit_hold;
    r.full = (fill_cnt >= eff);
    return r;
  endfunction

  function automatic row_t mk_row(input row_kind_e kind, input int value, input logic typed,
                                  input int avg, input int jit, input logic full_flag);
    row_t r;
    r.kind = kind;
    r.value = IN_BITS'(value);
    r.typed = typed;
    r.stats.average = OUT_BITS'(avg);
    r.stats.jitter = OUT_BITS'(jit);
    r.stats.full = full_flag;
    return r;
  endfunction

  task automatic add_row(input row_t r);
    dir_rows[n_rows] = r;
    n_rows++;
  endtask

  task automatic send_sample(input logic [IN_BITS-1:0] v, input logic typed,
                             input stats_t typed_stats);
    stats_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    latency_ms_i <= v;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pred = advance_window(v);
    exp_mem[exp_wr % EXP_DEPTH] = typed ? typed_stats : pred;
    exp_wr++;
  endtask

  task automatic write_window_length(input logic [CFG_BITS-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    win_len = v;
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    stats_t e;
    if (rst_ni && pop && !empty) begin
      if (exp_wr == exp_rd) begin
        $error("result beat with no expectation waiting");
        failures++;
      end else begin
        e = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (average_ms_o !== e.average) begin
          $error("average_ms expected %0d actual %0d", e.average, average_ms_o);
          failures++;
        end
        if (jitter_ms_o !== e.jitter) begin
          $error("jitter_ms expected %0d actual %0d", e.jitter, jitter_ms_o);
          failures++;
        end
        if (window_full_o !== e.full) begin
          $error("window_full expected %0d actual %0d", e.full, window_full_o);
          failures++;
        end
      end
    end
    pop <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    #(64'd40_000_000);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [CFG_BITS-1:0] phase_len [8];
    logic [IN_BITS-1:0]  latency;
    int                  base_ms;
    int                  p;
    int                  n;
    int                  k;
    stats_t              none;

    none = '0;
    phase_len = '{7'd16, 7'd1, 7'd64, 7'd5, 7'd127, 7'd0, 7'd2, 7'd33};

    add_row(mk_row(ROW_SAMPLE, 3, 1'b1, 0, 0, 1'b0));
    add_row(mk_row(ROW_CFG, 2, 1'b0, 0, 0, 1'b0));
    add_row(mk_row(ROW_SAMPLE, 0, 1'b1, 0, 0, 1'b1));
    add_row(mk_row(ROW_SAMPLE, 65535, 1'b1, 1, 0, 1'b1));
    add_row(mk_row(ROW_SAMPLE, 0, 1'b1, 32767, 32767, 1'b1));
    add_row(mk_row(ROW_CFG, 1, 1'b0, 0, 0, 1'b0));
    add_row(mk_row(ROW_SAMPLE, 65535, 1'b1, 32767, 0, 1'b1));
    add_row(mk_row(ROW_SAMPLE, 65535, 1'b1, 65535, 0, 1'b1));
    add_row(mk_row(ROW_CFG, 0, 1'b0, 0, 0, 1'b0));
    add_row(mk_row(ROW_SAMPLE, 0, 1'b1, 65535, 0, 1'b1));
    add_row(mk_row(ROW_SAMPLE, 1, 1'b1, 0, 0, 1'b1));
    add_row(mk_row(ROW_CFG, 127, 1'b0, 0, 0, 1'b0));
    add_row(mk_row(ROW_SAMPLE, 65535, 1'b0, 0, 0, 1'b0));
    add_row(mk_row(ROW_SAMPLE, 0, 1'b0, 0, 0, 1'b0));
    add_row(mk_row(ROW_SAMPLE, 40000, 1'b0, 0, 0, 1'b0));
    add_row(mk_row(ROW_SAMPLE, 12345, 1'b0, 0, 0, 1'b0));
    add_row(mk_row(ROW_SAMPLE, 65534, 1'b0, 0, 0, 1'b0));
    add_row(mk_row(ROW_SAMPLE, 0, 1'b0, 0, 0, 1'b0));
    add_row(mk_row(ROW_SAMPLE, 16'hAAAA, 1'b0, 0, 0, 1'b0));
    add_row(mk_row(ROW_SAMPLE, 16'h5555, 1'b0, 0, 0, 1'b0));
    add_row(mk_row(ROW_CFG, 64, 1'b0, 0, 0, 1'b0));
    add_row(mk_row(ROW_SAMPLE, 100, 1'b0, 0, 0, 1'b0));
    add_row(mk_row(ROW_CFG, 3, 1'b0, 0, 0, 1'b0));
    add_row(mk_row(ROW_SAMPLE, 16'h8000, 1'b0, 0, 0, 1'b0));
    add_row(mk_row(ROW_SAMPLE, 7, 1'b0, 0, 0, 1'b0));

    for (n = 0; n < WIN_MAX; n++) sample_mem[n] = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < n_rows; k++) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        drain_results();
        write_window_length(CFG_BITS'(dir_rows[k].value));
      end else begin
        send_sample(dir_rows[k].value, dir_rows[k].typed, dir_rows[k].stats);
      end
    end
    drain_results();

    for (p = 0; p < N_PHASES; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 60;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 60;
        end
        default: begin
          send_idle_pct = 11;
          recv_stall_pct = 11;
        end
      endcase
      if (p < 8) begin
        write_window_length(phase_len[p]);
      end else begin
        write_window_length(CFG_BITS'($urandom_range(1, 24)));
      end
      base_ms = $urandom_range(0, 65000);
      for (n = 0; n < PHASE_BEATS; n++) begin
        case ($urandom_range(0, 9))
          0: latency = '0;
          1: latency = '1;
          2: latency = IN_BITS'($urandom_range(0, 15));
          3, 4, 5: latency = IN_BITS'(base_ms + $urandom_range(0, 40));
          default: latency = IN_BITS'($urandom);
        endcase
        send_sample(latency, 1'b0, none);
      end
      drain_results();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (200) @(posedge clk_i);
    if (failures == 0 && exp_wr == exp_rd) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
